/* rtl/work_stealing_task_scheduler_top_defines.svh */
// assertion macros for the work stealing task scheduler
// used by the checker file; no other dependencies
`ifndef WORK_STEALING_TASK_SCHEDULER_TOP_DEFINES_SVH
`define WORK_STEALING_TASK_SCHEDULER_TOP_DEFINES_SVH

// clock and reset qualifier shared by every check
`define WSTS_CLK_RST @(posedge clk) disable iff (!rst_n)

// named concurrent check with an error report
`define WSTS_ASSERT(label, prop, msg) \
  label: assert property (`WSTS_CLK_RST prop) else $error(msg);

`endif

/* rtl/wsts_pkg.sv */
// package for the work stealing task scheduler
// holds sequencer states, request codes, status codes and register indexes
`default_nettype none

package wsts_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_MOD,
    S_SUB,
    S_SCAN,
    S_RD
  } state_t;

  typedef logic [1:0] req_t;
  localparam req_t REQ_SUBMIT   = 2'd0;
  localparam req_t REQ_FETCH    = 2'd1;
  localparam req_t REQ_SHUTDOWN = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t STS_ACCEPTED = 3'd0;
  localparam status_t STS_OWN      = 3'd1;
  localparam status_t STS_STOLEN   = 3'd2;
  localparam status_t STS_NONE     = 3'd3;
  localparam status_t STS_REFUSED  = 3'd4;
  localparam status_t STS_EXIT     = 3'd5;
  localparam status_t STS_FULL     = 3'd6;
  localparam status_t STS_BAD      = 3'd7;

  localparam logic REG_WORKER_COUNT = 1'b0;
  localparam logic [3:0] WORKER_COUNT_RESET = 4'd1;

endpackage

`default_nettype wire

/* rtl/work_stealing_task_scheduler_top.sv */
// work stealing task scheduler: per-worker deques in one task memory,
// sequenced by a small state machine around a shared queue cursor unit
// depends on wsts_pkg
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   request  | in_req_type, in_worker_id, in_task_id   | start when busy is low
//   result   | out_status, out_task_out, out_source_.. | out_valid, one cycle
//   config   | psel penable pwrite paddr pwdata prdata | apb write, pready high
//
// submit: decode, then the pointer is reduced by worker_count while it lies beyond
//   a shrunk count, then the write; refused submit, shutdown, bad worker end in decode
// own fetch: decode, then the read; steal: decode, a scan past empty queues, then the read;
//   miss: decode, then a scan of all the other queues
// one item at a time; the result shows in the first cycle with busy low
// rst_n is synchronous; results cannot be held off by the receiver
`default_nettype none

module work_stealing_task_scheduler_top #(
  parameter int MAX_WORKERS  = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [2:0]  in_worker_id,
  input  wire logic [15:0] in_task_id,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_task_out,
  output logic [2:0]       out_source_queue,
  output logic [7:0]       out_pending_tasks,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int QW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = ($clog2(MAX_WORKERS + 1) > 4) ? $clog2(MAX_WORKERS + 1) : 4;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = FW + 1;
  localparam int AW = $clog2(MAX_WORKERS * QUEUE_DEPTH);
  localparam int DEPTH = MAX_WORKERS * QUEUE_DEPTH;
  localparam int SW = (TASK_ID_BITS < 16) ? TASK_ID_BITS : 16;
  localparam int PW = $clog2(MAX_WORKERS * QUEUE_DEPTH + 1);
  localparam int PX = (PW > 8) ? PW : 8;

  wsts_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] front_r [MAX_WORKERS];
  logic [IW-1:0] front_nxt [MAX_WORKERS];
  logic [FW-1:0] fill_r [MAX_WORKERS];
  logic [FW-1:0] fill_nxt [MAX_WORKERS];
  logic [QW-1:0] rr_r, rr_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          stop_r, stop_nxt;
  logic [3:0]    wc_r;

  logic [1:0]    req_r;
  logic [2:0]    wid_r;
  logic [SW-1:0] tid_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_task_r;
  logic [2:0]    out_src_r, out_src_nxt;
  logic [7:0]    out_pend_r, out_pend_nxt;

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;

  logic          accept;
  logic          cfg_wr;
  logic [CW-1:0] wc_ext, mw_c, n_acc;
  logic [CW-1:0] wid_ext;
  logic [QW-1:0] widq, curq, scanq;
  logic [CW-1:0] cur_inc;
  logic [FW-1:0] fp1;
  logic [IW-1:0] f_inc, f_dec;
  logic [BW-1:0] back_sum;
  logic [IW-1:0] back_idx;
  logic [PX-1:0] pend_ext;
  logic [CW-1:0] src_ext;
  logic [QW-1:0] src_q;

  assign accept = start && (state_r == wsts_pkg::S_IDLE);
  assign busy   = (state_r != wsts_pkg::S_IDLE);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == wsts_pkg::REG_WORKER_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wsts_pkg::REG_WORKER_COUNT) ? {28'd0, wc_r} : 32'd0;

  assign wc_ext = CW'(wc_r);
  assign mw_c   = CW'(MAX_WORKERS);
  assign n_acc  = (wc_r == 4'd0) ? CW'(1) : ((wc_ext > mw_c) ? mw_c : wc_ext);

  assign wid_ext = CW'(wid_r);
  assign widq    = wid_ext[QW-1:0];
  assign curq    = cur_r[QW-1:0];
  assign cur_inc = ((cur_r + CW'(1)) == n_r) ? '0 : (cur_r + CW'(1));
  assign scanq   = cur_inc[QW-1:0];

  // queue cursor: the one queue whose ring pointers are worked on this cycle
  always_comb begin
    src_q = curq;
    unique case (state_r)
      wsts_pkg::S_DEC:  src_q = widq;
      wsts_pkg::S_SCAN: src_q = scanq;
      default:          src_q = curq;
    endcase
  end

  assign fp1      = FW'(front_r[src_q]) + FW'(1);
  assign f_inc    = (fp1 == FW'(QUEUE_DEPTH)) ? '0 : fp1[IW-1:0];
  assign f_dec    = (front_r[src_q] == '0) ? IW'(QUEUE_DEPTH - 1) : (front_r[src_q] - IW'(1));
  assign back_sum = BW'(front_r[src_q]) + BW'(fill_r[src_q]) - BW'(1);
  assign back_idx = (back_sum >= BW'(QUEUE_DEPTH)) ? IW'(back_sum - BW'(QUEUE_DEPTH))
                                                   : back_sum[IW-1:0];
  assign src_ext  = CW'(src_q);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    fill_nxt      = fill_r;
    rr_nxt        = rr_r;
    pend_nxt      = pend_r;
    stop_nxt      = stop_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = wsts_pkg::STS_NONE;
    out_src_nxt   = 3'd0;
    out_pend_nxt  = out_pend_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = AW'(src_q) * AW'(QUEUE_DEPTH) + AW'(front_r[src_q]);
    unique case (state_r)
      wsts_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = wsts_pkg::S_DEC;
        end
      end
      wsts_pkg::S_DEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = wsts_pkg::S_IDLE;
        priority if (req_r == wsts_pkg::REQ_SUBMIT) begin
          if (stop_r) begin
            out_status_nxt = wsts_pkg::STS_REFUSED;
          end else begin
            out_valid_nxt = 1'b0;
            cur_nxt       = CW'(rr_r);
            state_nxt     = wsts_pkg::S_MOD;
          end
        end else if (req_r == wsts_pkg::REQ_FETCH) begin
          if (wid_ext >= n_r) begin
            out_status_nxt = wsts_pkg::STS_BAD;
          end else if (fill_r[widq] != '0) begin
            out_valid_nxt    = 1'b0;
            mem_re           = 1'b1;
            front_nxt[widq]  = f_inc;
            fill_nxt[widq]   = fill_r[widq] - FW'(1);
            pend_nxt         = pend_r - PW'(1);
            out_status_nxt   = wsts_pkg::STS_OWN;
            out_src_nxt      = src_ext[2:0];
            state_nxt        = wsts_pkg::S_RD;
          end else begin
            out_valid_nxt = 1'b0;
            cur_nxt       = wid_ext;
            k_nxt         = CW'(1);
            state_nxt     = wsts_pkg::S_SCAN;
          end
        end else if (req_r == wsts_pkg::REQ_SHUTDOWN) begin
          stop_nxt       = 1'b1;
          out_status_nxt = wsts_pkg::STS_ACCEPTED;
        end else begin
          out_status_nxt = wsts_pkg::STS_NONE;
        end
      end
      wsts_pkg::S_MOD: begin
        if (cur_r >= n_r) begin
          cur_nxt = cur_r - n_r;
        end else begin
          state_nxt = wsts_pkg::S_SUB;
        end
      end
      wsts_pkg::S_SUB: begin
        out_valid_nxt = 1'b1;
        out_src_nxt   = src_ext[2:0];
        state_nxt     = wsts_pkg::S_IDLE;
        if (fill_r[curq] >= FW'(QUEUE_DEPTH)) begin
          out_status_nxt = wsts_pkg::STS_FULL;
        end else begin
          mem_we          = 1'b1;
          mem_addr        = AW'(curq) * AW'(QUEUE_DEPTH) + AW'(f_dec);
          front_nxt[curq] = f_dec;
          fill_nxt[curq]  = fill_r[curq] + FW'(1);
          rr_nxt          = cur_inc[QW-1:0];
          pend_nxt        = pend_r + PW'(1);
          out_status_nxt  = wsts_pkg::STS_ACCEPTED;
        end
      end
      wsts_pkg::S_SCAN: begin
        if (k_r >= n_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (stop_r && (pend_r == '0)) ? wsts_pkg::STS_EXIT
                                                      : wsts_pkg::STS_NONE;
          state_nxt      = wsts_pkg::S_IDLE;
        end else if (fill_r[scanq] != '0) begin
          mem_re          = 1'b1;
          mem_addr        = AW'(scanq) * AW'(QUEUE_DEPTH) + AW'(back_idx);
          fill_nxt[scanq] = fill_r[scanq] - FW'(1);
          pend_nxt        = pend_r - PW'(1);
          out_status_nxt  = wsts_pkg::STS_STOLEN;
          out_src_nxt     = src_ext[2:0];
          state_nxt       = wsts_pkg::S_RD;
        end else begin
          cur_nxt = cur_inc;
          k_nxt   = k_r + CW'(1);
        end
      end
      wsts_pkg::S_RD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = out_status_r;
        out_src_nxt    = out_src_r;
        out_pend_nxt   = out_pend_r;
        state_nxt      = wsts_pkg::S_IDLE;
      end
      default: begin
        state_nxt = wsts_pkg::S_IDLE;
      end
    endcase
    pend_ext = PX'(pend_nxt);
    if (state_r != wsts_pkg::S_RD) begin
      out_pend_nxt = pend_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsts_pkg::S_IDLE;
      rr_r        <= '0;
      pend_r      <= '0;
      stop_r      <= 1'b0;
      wc_r        <= wsts_pkg::WORKER_COUNT_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        front_r[i] <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rr_r        <= rr_nxt;
      pend_r      <= pend_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
      front_r     <= front_nxt;
      fill_r      <= fill_nxt;
      if (cfg_wr) begin
        wc_r <= pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      wid_r <= in_worker_id;
      tid_r <= in_task_id[SW-1:0];
      n_r   <= n_acc;
    end
    cur_r        <= cur_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_pend_r   <= out_pend_nxt;
    out_task_r   <= (state_r == wsts_pkg::S_RD) ? 16'(rdata_r) : 16'd0;
  end

  // task memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= tid_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_task_out      = out_task_r;
  assign out_source_queue  = out_src_r;
  assign out_pending_tasks = out_pend_r;

endmodule

`default_nettype wire

/* rtl/wsts_checker.sv */
// port-level checks for the work stealing task scheduler
// depends on wsts_pkg and the defines header; bound to the top level below
`default_nettype none

`include "work_stealing_task_scheduler_top_defines.svh"

module wsts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_task_out
);

  logic no_handout;

  assign no_handout = (out_status != wsts_pkg::STS_OWN) && (out_status != wsts_pkg::STS_STOLEN);

  // accepted item makes the block busy
  `WSTS_ASSERT(a_accept_busy, start && !busy |=> busy, "accept did not raise busy")

  // result only after busy work and with the block already free
  `WSTS_ASSERT(a_out_after_busy, out_valid |-> $past(busy) && !busy, "result out of sequence")

  // one result per item, never two in a row
  `WSTS_ASSERT(a_single_result, out_valid |=> !out_valid, "repeated result")

  // a task id is shown only when one is handed out
  `WSTS_ASSERT(a_task_zero, out_valid && no_handout |-> out_task_out == 16'd0, "task id leak")

endmodule

bind work_stealing_task_scheduler_top wsts_checker u_wsts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_task_out (out_task_out)
);

`default_nettype wire
